### rtl/pcrld_pkg.sv
// shared types and constants for the packed-code run-length decoder
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps
`default_nettype none

package pcrld_pkg;

  localparam int BOARD_CELLS_DEF = 4096;
  localparam int QUEUE_DEPTH     = 2;

  localparam int BYTE_W      = 8;
  localparam int STORE_W     = 20;
  localparam int HELD_W      = 5;
  localparam int TILE_W      = 12;
  localparam int COUNT_W     = 8;
  localparam int CELL_W      = 12;

  localparam logic [HELD_W-1:0] WIDE_CODE_BITS   = 5'd13;
  localparam logic [HELD_W-1:0] NARROW_CODE_BITS = 5'd12;
  localparam int                PAIR_FLAG_BIT    = 8;

  typedef enum logic {
    CODE_DATA = 1'b0,
    CODE_CTRL = 1'b1
  } code_kind_e;

  // one extracted code, classified by the front end
  typedef struct packed {
    code_kind_e          kind;
    logic [TILE_W-1:0]   value;
  } code_t;

  // one run descriptor as presented on the output channel
  typedef struct packed {
    logic [CELL_W-1:0]   start_cell;
    logic [TILE_W-1:0]   first_tile;
    logic [TILE_W-1:0]   second_tile;
    logic                is_pair;
    logic [COUNT_W-1:0]  repeat_count;
    logic                board_full;
  } run_t;

endpackage

`default_nettype wire

### rtl/packed_code_run_length_decoder_core.sv
// packed-code run-length decoder: usage notes
// input channel: in_valid_i / in_stall_o with data_byte_i, one byte per item,
//   taken at an edge with valid high and stall low. bytes are unpacked lsb
//   first into 12 or 13 bit codes; each byte completes at most one code.
// output channel: out_valid_o / out_stall_i with one run descriptor per item;
//   payload holds while out_stall_i is high.
// config channel: cfg_valid_i / cfg_ready_o writes cfg_wide_codes_i
//   (1 = 13-bit codes, 0 = 12-bit codes); ready is always high. write only
//   while the block is idle. reset value is 1.
// throughput: one byte per cycle, sustained, while the output is not stalled.
// path: the code that a byte completes is written into the two-entry code
//   queue (front extraction); the run engine takes it and registers its descriptor.
// stall: a stalled output register holds the run engine; the code queue
//   fills and in_stall_o rises once both entries are taken.
// reset: asynchronous, active low; clears the bit gatherer, the queue, run
//   count to one and the board position to zero. after the board is full
//   bytes are still taken but give no result until the next reset.
`timescale 1ns / 1ps
`default_nettype none

module packed_code_run_length_decoder_core #(
  parameter int BOARD_CELLS = pcrld_pkg::BOARD_CELLS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,

  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire                            cfg_wide_codes_i,

  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire [pcrld_pkg::BYTE_W-1:0]    data_byte_i,

  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [pcrld_pkg::CELL_W-1:0]   start_cell_o,
  output logic [pcrld_pkg::TILE_W-1:0]   first_tile_o,
  output logic [pcrld_pkg::TILE_W-1:0]   second_tile_o,
  output logic                           is_pair_o,
  output logic [pcrld_pkg::COUNT_W-1:0]  repeat_count_o,
  output logic                           board_full_o
);

  logic              q_full;
  logic              byte_fire;
  logic              push;
  pcrld_pkg::code_t  push_code;
  logic              pop;
  logic              head_valid;
  pcrld_pkg::code_t  head;
  pcrld_pkg::run_t   run;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign byte_fire   = in_valid_i && !q_full;

  pcrld_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_wide_codes_i (cfg_wide_codes_i),
    .byte_fire_i      (byte_fire),
    .data_byte_i      (data_byte_i),
    .push_o           (push),
    .code_o           (push_code)
  );

  pcrld_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_code_i  (push_code),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  pcrld_back #(
    .BOARD_CELLS (BOARD_CELLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .run_o        (run)
  );

  assign start_cell_o   = run.start_cell;
  assign first_tile_o   = run.first_tile;
  assign second_tile_o  = run.second_tile;
  assign is_pair_o      = run.is_pair;
  assign repeat_count_o = run.repeat_count;
  assign board_full_o   = run.board_full;

endmodule

`default_nettype wire

### rtl/pcrld_front.sv
// front end: gathers input bytes lsb first and extracts 12 or 13 bit codes
// holds the code width register; depends on pcrld_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcrld_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire                          cfg_wide_codes_i,
  input  wire                          byte_fire_i,
  input  wire [pcrld_pkg::BYTE_W-1:0]  data_byte_i,
  output logic                         push_o,
  output pcrld_pkg::code_t             code_o
);

  logic                            wide_q;
  logic [pcrld_pkg::STORE_W-1:0]   bit_store_q, bit_store_d;
  logic [pcrld_pkg::HELD_W-1:0]    bits_held_q, bits_held_d;

  logic [pcrld_pkg::HELD_W-1:0]    code_bits;
  logic [pcrld_pkg::HELD_W-1:0]    held_sum;
  logic [pcrld_pkg::STORE_W-1:0]   byte_sh;
  logic [pcrld_pkg::STORE_W-1:0]   merged;
  logic                            extract;
  logic                            ctrl_bit;

  always_comb begin
    code_bits = wide_q ? pcrld_pkg::WIDE_CODE_BITS : pcrld_pkg::NARROW_CODE_BITS;
    held_sum  = bits_held_q + 5'd8;
    // held bits never exceed 12 before a byte is added, so the shift fits 20 bits
    byte_sh   = pcrld_pkg::STORE_W'(data_byte_i) << bits_held_q[3:0];
    merged    = bit_store_q | byte_sh;
    extract   = held_sum >= code_bits;
    ctrl_bit  = wide_q ? merged[12] : merged[11];

    bit_store_d = bit_store_q;
    bits_held_d = bits_held_q;
    if (byte_fire_i) begin
      if (extract) begin
        bit_store_d = merged >> code_bits;
        bits_held_d = held_sum - code_bits;
      end else begin
        bit_store_d = merged;
        bits_held_d = held_sum;
      end
    end

    push_o       = byte_fire_i && extract;
    code_o.kind  = ctrl_bit ? pcrld_pkg::CODE_CTRL : pcrld_pkg::CODE_DATA;
    code_o.value = merged[pcrld_pkg::TILE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q      <= 1'b1;
      bit_store_q <= '0;
      bits_held_q <= '0;
    end else begin
      if (cfg_we_i) begin
        wide_q <= cfg_wide_codes_i;
      end
      bit_store_q <= bit_store_d;
      bits_held_q <= bits_held_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_held_q <= pcrld_pkg::NARROW_CODE_BITS)
    else $error("front holds more bits than a code");
`endif

endmodule

`default_nettype wire

### rtl/pcrld_queue.sv
// short code queue between the front end and the run engine
// register based, one push (unless full) and one pop per cycle; depends on pcrld_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcrld_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  pcrld_pkg::code_t   push_code_i,
  input  wire                pop_i,
  output logic               full_o,
  output logic               head_valid_o,
  output pcrld_pkg::code_t   head_o
);

  localparam int Depth = pcrld_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  pcrld_pkg::code_t  slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  always_comb begin
    full_o       = count_q == CntW'(Depth);
    head_valid_o = count_q != '0;
    head_o       = slots_q[rd_ptr_q];
    do_push      = push_i && !full_o;
    do_pop       = pop_i && head_valid_o;

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("code pushed into a full queue");
`endif

endmodule

`default_nettype wire

### rtl/pcrld_back.sv
// run engine: applies control codes, pairs tiles, clips runs to the board
// and holds the output descriptor register; depends on pcrld_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcrld_back #(
  parameter int BOARD_CELLS = pcrld_pkg::BOARD_CELLS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                head_valid_i,
  input  pcrld_pkg::code_t   head_i,
  output logic               pop_o,
  input  wire                out_stall_i,
  output logic               out_valid_o,
  output pcrld_pkg::run_t    run_o
);

  localparam int CW = $clog2(BOARD_CELLS + 1);
  localparam int XW = (CW > pcrld_pkg::CELL_W) ? CW : pcrld_pkg::CELL_W;

  logic [CW-1:0]                    pos_q, pos_d;
  logic [pcrld_pkg::TILE_W-1:0]     held_tile_q, held_tile_d;
  logic                             held_valid_q, held_valid_d;
  logic                             pair_mode_q, pair_mode_d;
  logic [pcrld_pkg::COUNT_W-1:0]    run_count_q, run_count_d;
  logic                             out_valid_q, out_valid_d;
  pcrld_pkg::run_t                  run_q, run_d;
  logic                             load;

  logic [XW-1:0] pos_x, cells_x, left_x, lim_x, rc_x, reps_x, adv_x, next_x;
  logic          full;

  always_comb begin
    pos_x   = XW'(pos_q);
    cells_x = XW'(BOARD_CELLS);
    full    = pos_x >= cells_x;
    left_x  = cells_x - pos_x;
    lim_x   = pair_mode_q ? (left_x >> 1) : left_x;
    rc_x    = XW'(run_count_q);
    reps_x  = (rc_x > lim_x) ? lim_x : rc_x;
    adv_x   = pair_mode_q ? (reps_x << 1) : reps_x;
    next_x  = pos_x + adv_x;

    pop_o = head_valid_i && (!out_valid_q || !out_stall_i);

    pos_d        = pos_q;
    held_tile_d  = held_tile_q;
    held_valid_d = held_valid_q;
    pair_mode_d  = pair_mode_q;
    run_count_d  = run_count_q;
    load         = 1'b0;

    run_d.start_cell   = pos_x[pcrld_pkg::CELL_W-1:0];
    run_d.first_tile   = pair_mode_q ? held_tile_q : head_i.value;
    run_d.second_tile  = pair_mode_q ? head_i.value : '0;
    run_d.is_pair      = pair_mode_q;
    run_d.repeat_count = reps_x[pcrld_pkg::COUNT_W-1:0];
    run_d.board_full   = next_x >= cells_x;

    // once the board is full every remaining code is dropped
    if (pop_o && !full) begin
      case (head_i.kind)
        pcrld_pkg::CODE_CTRL: begin
          pair_mode_d = head_i.value[pcrld_pkg::PAIR_FLAG_BIT];
          run_count_d = head_i.value[pcrld_pkg::COUNT_W-1:0];
        end
        pcrld_pkg::CODE_DATA: begin
          if (pair_mode_q && !held_valid_q) begin
            held_tile_d  = head_i.value;
            held_valid_d = 1'b1;
          end else begin
            load        = 1'b1;
            pos_d       = next_x[CW-1:0];
            run_count_d = 8'd1;
            if (pair_mode_q) begin
              held_tile_d  = '0;
              held_valid_d = 1'b0;
              pair_mode_d  = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end

    out_valid_o = out_valid_q;
    run_o       = run_q;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      held_tile_q  <= '0;
      held_valid_q <= 1'b0;
      pair_mode_q  <= 1'b0;
      run_count_q  <= 8'd1;
      out_valid_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      held_tile_q  <= held_tile_d;
      held_valid_q <= held_valid_d;
      pair_mode_q  <= pair_mode_d;
      run_count_q  <= run_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_x <= cells_x)
    else $error("cell position past the end of the board");

  a_single_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !run_q.is_pair) |-> (run_q.second_tile == '0))
    else $error("single run carries a second tile");

  a_full_flag_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && run_d.board_full) |=> full)
    else $error("board full flag given but position not at the end");
`endif

endmodule

`default_nettype wire
